// ===== rtl/pst_pkg.sv =====
// Package for the polyline stroke triangulator.
// Holds triangle kinds and fixed widths; no dependencies.
package pst_pkg;
  localparam int CoordW = 32;
  localparam int NormW  = 18;
  localparam int HwW    = 31;

  typedef enum logic [1:0] {
    KIND_QUAD0 = 2'd0,
    KIND_QUAD1 = 2'd1,
    KIND_JOINU = 2'd2,
    KIND_JOINL = 2'd3
  } tri_kind_t;

  localparam logic CFG_JOIN = 1'b0;
  localparam logic CFG_EPS  = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    else if (v < -35'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage

// ===== rtl/polyline_stroke_triangulator.sv =====
// Polyline stroke triangulator, top level.
// Uses pst_pkg; one shared sqrt/divide/multiply sequencer.
//
// A point that closes a segment keeps in_stall high until its two triangles,
// or four with the join, have been made and taken; a stalled output lengthens
// the stall. The time goes to a difference step, squaring of adx and then
// of ady, a 32-step square root plus a settle step, two 50-step restoring
// divisions (one quotient bit per cycle) plus a rounding step each, and six
// sequential 18x32 multiplies. Then the triangles are sent one word per
// handshake through an output register, and the point is stored as the last
// word is taken. A degenerate segment stalls only up to the end of the square
// root and makes no triangle; a first point never stalls.
module polyline_stroke_triangulator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic [30:0]          in_half_width,
  input  logic                 in_first_point,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_v0_x,
  output logic signed [31:0]   out_v0_y,
  output logic signed [31:0]   out_v1_x,
  output logic signed [31:0]   out_v1_y,
  output logic signed [31:0]   out_v2_x,
  output logic signed [31:0]   out_v2_y,
  output pst_pkg::tri_kind_t   out_tri_kind,
  output logic                 out_last_of_run,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);
  import pst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_SQRT, S_DIVX, S_DIVY, S_MUL, S_EMIT
  } state_t;

  state_t state_r;
  logic join_en_r;
  logic [15:0] eps_r;
  logic signed [31:0] px_r, py_r, x_r, y_r;
  logic [30:0] pw_r, hw_r;
  logic signed [NormW-1:0] pnx_r, pny_r, nx_r, ny_r;
  logic have_r;
  logic [31:0] adx_r, ady_r;
  logic sx_r, sy_r, halved_r;
  logic [63:0] acc_r;
  logic [63:0] rem_r;
  logic [31:0] root_r;
  logic [5:0] cnt_r;
  logic [49:0] q_r;
  logic [50:0] drem_r;
  logic [49:0] dnum_r;
  logic signed [34:0] off_r [6];
  logic [2:0] mi_r;
  logic [1:0] ti_r;
  logic [1:0] nt_r;

  // square root step
  logic [63:0] sq_trial;
  logic [65:0] sq_rem;
  assign sq_rem   = {rem_r, acc_r[63:62]};
  assign sq_trial = 64'({root_r, 2'b01});
  // divide step
  logic [50:0] dv_sh;
  assign dv_sh = {drem_r[49:0], dnum_r[49]};

  // shared multiplier operand select
  logic signed [NormW-1:0] m_n;
  logic [30:0] m_w;
  always_comb begin
    unique case (mi_r)
      3'd0: begin m_n = nx_r;  m_w = pw_r; end
      3'd1: begin m_n = ny_r;  m_w = pw_r; end
      3'd2: begin m_n = nx_r;  m_w = hw_r; end
      3'd3: begin m_n = ny_r;  m_w = hw_r; end
      3'd4: begin m_n = pnx_r; m_w = pw_r; end
      default: begin m_n = pny_r; m_w = pw_r; end
    endcase
  end
  logic signed [49:0] m_p;
  logic [49:0] m_mag;
  logic [34:0] m_q;
  assign m_p   = m_n * $signed({1'b0, m_w});
  assign m_mag = m_p[49] ? 50'(-m_p) : m_p;
  assign m_q   = 35'((m_mag + 50'd32768) >> 16);

  logic [49:0] q_rnd;
  logic [50:0] q_plus;
  assign q_plus = {1'b0, q_r} + 51'd1;
  assign q_rnd  = (drem_r >= 51'(root_r - (root_r >> 1))) ? q_plus[49:0] : q_r;

  logic signed [32:0] ddx, ddy;
  assign ddx = 33'(in_pos_x) - 33'(px_r);
  assign ddy = 33'(in_pos_y) - 33'(py_r);

  // vertex build
  logic signed [34:0] cx, cy, ux0, uy0, lx0, ly0, ux1, uy1, lx1, ly1, jux, juy, jlx, jly;
  always_comb begin
    cx  = 35'(px_r); cy = 35'(py_r);
    ux0 = cx + off_r[0]; uy0 = cy + off_r[1];
    lx0 = cx - off_r[0]; ly0 = cy - off_r[1];
    ux1 = 35'(x_r) + off_r[2]; uy1 = 35'(y_r) + off_r[3];
    lx1 = 35'(x_r) - off_r[2]; ly1 = 35'(y_r) - off_r[3];
    jux = cx + off_r[4]; juy = cy + off_r[5];
    jlx = cx - off_r[4]; jly = cy - off_r[5];
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; join_en_r <= 1'b1; eps_r <= '0;
      px_r <= '0; py_r <= '0; pw_r <= '0; pnx_r <= '0; pny_r <= '0;
      have_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_JOIN: join_en_r <= cfg_data[0];
          default:  eps_r <= cfg_data;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          x_r <= in_pos_x; y_r <= in_pos_y; hw_r <= in_half_width;
          if (in_first_point || !have_r) begin
            pnx_r <= '0; pny_r <= '0;
            px_r <= in_pos_x; py_r <= in_pos_y; pw_r <= in_half_width;
            have_r <= 1'b1;
          end else begin
            sx_r <= ddx[32]; sy_r <= ddy[32];
            adx_r <= ddx[32] ? 32'(-ddx) : ddx[31:0];
            ady_r <= ddy[32] ? 32'(-ddy) : ddy[31:0];
            halved_r <= 1'b0;
            if (ddx[32] ? (-ddx > 33'sd2147483647) : ddx[31])
              halved_r <= 1'b1;
            if (ddy[32] ? (-ddy > 33'sd2147483647) : ddy[31])
              halved_r <= 1'b1;
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (halved_r) begin
            adx_r <= adx_r >> 1; ady_r <= ady_r >> 1;
          end
          mi_r <= 3'd0; state_r <= S_SQ;
        end
        S_SQ: begin
          // reuse of the multiplier count: first adx^2, then add ady^2
          if (mi_r == 3'd0) begin
            acc_r <= adx_r * adx_r; mi_r <= 3'd1;
          end else begin
            acc_r <= acc_r + ady_r * ady_r;
            rem_r <= '0; root_r <= '0; cnt_r <= '0; state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt_r == 6'd32) begin
            // root_r settled; check degenerate
            if (root_r == '0 || (!halved_r && root_r <= 32'(eps_r))) begin
              pnx_r <= '0; pny_r <= '0;
              px_r <= x_r; py_r <= y_r; pw_r <= hw_r;
              state_r <= S_IDLE;
            end else begin
              dnum_r <= 50'(ady_r) << 16; drem_r <= '0; q_r <= '0;
              cnt_r <= '0; state_r <= S_DIVX;
            end
          end else begin
            if (sq_rem >= 66'(sq_trial)) begin
              rem_r <= 64'(sq_rem - 66'(sq_trial)); root_r <= {root_r[30:0], 1'b1};
            end else begin
              rem_r <= sq_rem[63:0]; root_r <= {root_r[30:0], 1'b0};
            end
            acc_r <= acc_r << 2;
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_DIVX, S_DIVY: begin
          if (cnt_r < 6'd50) begin
            if (dv_sh >= 51'(root_r)) begin
              drem_r <= dv_sh - 51'(root_r); q_r <= {q_r[48:0], 1'b1};
            end else begin
              drem_r <= dv_sh; q_r <= {q_r[48:0], 1'b0};
            end
            dnum_r <= dnum_r << 1;
            cnt_r <= cnt_r + 6'd1;
          end else if (state_r == S_DIVX) begin
            nx_r <= sy_r ? NormW'(q_rnd) : NormW'(-q_rnd);
            dnum_r <= 50'(adx_r) << 16; drem_r <= '0; q_r <= '0;
            cnt_r <= '0; state_r <= S_DIVY;
          end else begin
            ny_r <= sx_r ? NormW'(-q_rnd) : NormW'(q_rnd);
            mi_r <= '0; state_r <= S_MUL;
          end
        end
        S_MUL: begin
          off_r[mi_r] <= m_p[49] ? -$signed(m_q) : $signed(m_q);
          if (mi_r == 3'd5) begin
            nt_r <= (join_en_r && (pnx_r != '0 || pny_r != '0)) ? 2'd3 : 2'd1;
            ti_r <= '0; state_r <= S_EMIT;
          end
          mi_r <= mi_r + 3'd1;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            if (out_valid && out_last_of_run) begin
              out_valid <= 1'b0;
              pnx_r <= nx_r; pny_r <= ny_r;
              px_r <= x_r; py_r <= y_r; pw_r <= hw_r;
              state_r <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_last_of_run <= (ti_r == nt_r);
              out_tri_kind <= tri_kind_t'(ti_r);
              unique case (ti_r)
                2'd0: begin
                  out_v0_x <= sat32(ux0); out_v0_y <= sat32(uy0);
                  out_v1_x <= sat32(ux1); out_v1_y <= sat32(uy1);
                  out_v2_x <= sat32(lx0); out_v2_y <= sat32(ly0);
                end
                2'd1: begin
                  out_v0_x <= sat32(lx0); out_v0_y <= sat32(ly0);
                  out_v1_x <= sat32(ux1); out_v1_y <= sat32(uy1);
                  out_v2_x <= sat32(lx1); out_v2_y <= sat32(ly1);
                end
                2'd2: begin
                  out_v0_x <= px_r; out_v0_y <= py_r;
                  out_v1_x <= sat32(jux); out_v1_y <= sat32(juy);
                  out_v2_x <= sat32(ux0); out_v2_y <= sat32(uy0);
                end
                default: begin
                  out_v0_x <= px_r; out_v0_y <= py_r;
                  out_v1_x <= sat32(lx0); out_v1_y <= sat32(ly0);
                  out_v2_x <= sat32(jlx); out_v2_y <= sat32(jly);
                end
              endcase
              if (ti_r != nt_r) ti_r <= ti_r + 2'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_EMIT) else $error("result outside emit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_v0_x) && $stable(out_tri_kind))
    else $error("stalled word changed");
  a_nostall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !out_valid) else $error("word left in idle");
`endif
endmodule
